@@ src/waypoint_step_follower_top_defines.svh @@
// Assertion macros for the waypoint step follower.
// Used by waypoint_step_follower_top; expects clk and rst_n in scope.
`ifndef WAYPOINT_STEP_FOLLOWER_TOP_DEFINES_SVH
`define WAYPOINT_STEP_FOLLOWER_TOP_DEFINES_SVH

// Checked only outside reset.
`define WSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define WSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/wsf_pkg.sv @@
// Shared types and constants for the waypoint step follower.
// No dependencies; used by wsf_ctrl, wsf_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wsf_pkg;

    localparam int OP_BITS = 2;
    localparam int Z_BITS  = 2;

    localparam logic [OP_BITS-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic exec;      // apply push / clear / drop flag
        logic pop;       // retire head waypoint
        logic load_out;  // load the result register
    } wsf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_tick;
        logic count_zero;
        logic count_one;
        logic head_match;
        logic out_free;
    } wsf_sts_t;

endpackage

`default_nettype wire

@@ src/waypoint_step_follower_top.sv @@
// Waypoint step follower: a queue of x,y waypoints that steps a position.
// Channels: input (opcode, pos_x, pos_y, pos_z) and output (next_x, next_y,
// next_z, path_empty, push_dropped), each with valid and stall; a
// transaction moves on an edge where valid is high and stall is low.
// Every input transaction yields exactly one output transaction, in order.
// Opcodes: push appends a waypoint (flags push_dropped when full), tick
// retires reached waypoints and steps one unit toward the next, clear
// empties the queue.
// Timing: one transaction at a time. Push, clear, unused opcodes and a tick
// on an empty queue go from acceptance through the execute state to the
// result state; any other tick adds a compare state, then per retired
// waypoint a fetch (the registered memory read) and another compare, except
// after a retire that empties the queue. The next input is taken the cycle
// after the result is loaded, while that result may still be waiting.
// Stall: a stalled result holds in the output register; a further result
// waits in the controller until the register frees, stalling the input.
// Reset: queue empty, pointers zero, no result pending; memory contents are
// not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "waypoint_step_follower_top_defines.svh"

module waypoint_step_follower_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int COORD_BITS  = 14
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [wsf_pkg::OP_BITS-1:0]        opcode,
    input  wire  [COORD_BITS-1:0]              pos_x,
    input  wire  [COORD_BITS-1:0]              pos_y,
    input  wire  [wsf_pkg::Z_BITS-1:0]         pos_z,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [COORD_BITS:0]         next_x,
    output logic signed [COORD_BITS:0]         next_y,
    output logic signed [wsf_pkg::Z_BITS:0]    next_z,
    output logic                               path_empty,
    output logic                               push_dropped
);

    wsf_pkg::wsf_cmd_t cmd;
    wsf_pkg::wsf_sts_t sts;

    wsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .next_x       (next_x),
        .next_y       (next_y),
        .next_z       (next_z),
        .path_empty   (path_empty),
        .push_dropped (push_dropped)
    );

    // one transaction in flight: acceptance closes the input for the next cycle
    `WSF_ASSERT(a_single_in_flight, (in_valid && !in_stall) |=> in_stall, "second transaction accepted while busy")
    // a pop only retires a non-empty, matching head
    `WSF_ASSERT(a_pop_legal, cmd.pop |-> (sts.head_match && !sts.count_zero), "pop without matching head")
    // result register is never overwritten while a stalled result waits
    `WSF_ASSERT_ALWAYS(a_no_overwrite, (out_valid && out_stall) |-> !cmd.load_out, "result overwritten under stall")

endmodule

`default_nettype wire

@@ src/wsf_datapath.sv @@
// Datapath: input latch, waypoint memory, queue pointers and result register.
// Depends on wsf_pkg; driven by wsf_ctrl through wsf_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module wsf_datapath #(
    parameter int QUEUE_DEPTH = 32,
    parameter int COORD_BITS  = 14
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wsf_pkg::wsf_cmd_t                  cmd,
    output wsf_pkg::wsf_sts_t                  sts,
    input  wire  [wsf_pkg::OP_BITS-1:0]        opcode,
    input  wire  [COORD_BITS-1:0]              pos_x,
    input  wire  [COORD_BITS-1:0]              pos_y,
    input  wire  [wsf_pkg::Z_BITS-1:0]         pos_z,
    input  wire                                out_stall,
    output logic                               out_valid,
    output logic signed [COORD_BITS:0]         next_x,
    output logic signed [COORD_BITS:0]         next_y,
    output logic signed [wsf_pkg::Z_BITS:0]    next_z,
    output logic                               path_empty,
    output logic                               push_dropped
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 2 * COORD_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX   = IW'(QUEUE_DEPTH - 1);

    logic [wsf_pkg::OP_BITS-1:0] op_reg;
    logic [COORD_BITS-1:0]       px_reg;
    logic [COORD_BITS-1:0]       py_reg;
    logic [wsf_pkg::Z_BITS-1:0]  pz_reg;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;

    logic                            out_valid_reg, out_valid_next;
    logic signed [COORD_BITS:0]      nx_reg;
    logic signed [COORD_BITS:0]      ny_reg;
    logic signed [wsf_pkg::Z_BITS:0] nz_reg;
    logic                            empty_reg;
    logic                            drop_out_reg;

    logic [COORD_BITS-1:0] tgt_x, tgt_y;
    logic [COORD_BITS-1:0] step_x, step_y;
    logic                  is_push, is_tick, is_clear, full, do_write;
    logic                  out_free;

    assign tgt_x    = rd_reg[EW-1:COORD_BITS];
    assign tgt_y    = rd_reg[COORD_BITS-1:0];
    assign is_push  = (op_reg == wsf_pkg::OP_PUSH);
    assign is_tick  = (op_reg == wsf_pkg::OP_TICK);
    assign is_clear = (op_reg == wsf_pkg::OP_CLEAR);
    assign full     = (count_reg == FULL_COUNT);
    assign do_write = cmd.exec && is_push && !full;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (px_reg < tgt_x)
            step_x = px_reg + COORD_BITS'(1);
        else if (px_reg > tgt_x)
            step_x = px_reg - COORD_BITS'(1);
        else
            step_x = px_reg;
        if (py_reg < tgt_y)
            step_y = py_reg + COORD_BITS'(1);
        else if (py_reg > tgt_y)
            step_y = py_reg - COORD_BITS'(1);
        else
            step_y = py_reg;
    end

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.exec)
        begin
            dropped_next = is_push && full;
            if (is_clear)
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            else if (do_write)
            begin
                tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
                count_next = count_reg + CW'(1);
            end
        end
        else if (cmd.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Head entry is read every cycle through a register; it is stable the cycle after head moves.
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[tail_reg] <= {px_reg, py_reg};
        rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= opcode;
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
        if (cmd.load_out)
        begin
            if (is_tick && count_reg != '0)
            begin
                nx_reg <= {1'b0, step_x};
                ny_reg <= {1'b0, step_y};
                nz_reg <= {1'b0, pz_reg};
            end
            else
            begin
                nx_reg <= '1;
                ny_reg <= '1;
                nz_reg <= '1;
            end
            empty_reg    <= (count_reg == '0);
            drop_out_reg <= dropped_reg;
        end
    end

    assign sts.op_tick    = is_tick;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == CW'(1));
    assign sts.head_match = (tgt_x == px_reg) && (tgt_y == py_reg);
    assign sts.out_free   = out_free;

    assign out_valid    = out_valid_reg;
    assign next_x       = nx_reg;
    assign next_y       = ny_reg;
    assign next_z       = nz_reg;
    assign path_empty   = empty_reg;
    assign push_dropped = drop_out_reg;

endmodule

`default_nettype wire

@@ src/wsf_ctrl.sv @@
// Controller state machine for the waypoint step follower.
// Depends on wsf_pkg; sequences wsf_datapath through wsf_cmd_t / wsf_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module wsf_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wsf_pkg::wsf_sts_t  sts,
    output wsf_pkg::wsf_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.op_tick && !sts.count_zero)
                    state_next = S_CMP;
                else
                    state_next = S_RESULT;
            end
            S_CMP:
            begin
                if (sts.head_match)
                begin
                    cmd.pop    = 1'b1;
                    // last waypoint reached: nothing left to fetch
                    state_next = sts.count_one ? S_RESULT : S_FETCH;
                end
                else
                    state_next = S_RESULT;
            end
            S_FETCH:
                state_next = S_CMP;
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire
